// ----- hw/rtl/buddy_block_allocator_macros.svh -----
// ---------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Concurrent assertion wrappers; they expand to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBA_ASSERT(lbl, clk, rstn, prop, msg)
`define BBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/bba_pkg.sv -----
// ---------------------------------------------------------------------------
// Buddy block allocator package
// Default sizes and request codes used by the allocator module.
// ---------------------------------------------------------------------------
package bba_pkg;
	localparam int DEF_TABLE_SLOTS = 64;
	localparam int DEF_TOP_ORDER   = 12;
	localparam int SIZE_W          = 4;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	function automatic int order_width(input int top_order);
		int w;
		w = $clog2(top_order + 1);
		return (w > SIZE_W) ? w : SIZE_W;
	endfunction
endpackage

// ----- hw/rtl/bba_ram.sv -----
// ---------------------------------------------------------------------------
// Buddy block allocator RAM
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- hw/rtl/buddy_block_allocator.sv -----
// ---------------------------------------------------------------------------
// Buddy block allocator
// Ordered block table with split on allocate and merge on free.
// ---------------------------------------------------------------------------
// Usage: a request (cmd, size_order) is a transaction on the in channel;
// cmd selects allocate or free. Each request returns exactly one ok flag
// on the out channel. The block table lives in a RAM with a registered
// read port; a table scan reads the entries in turn, and a shift reads
// each entry moved and writes it one slot over. An allocate costs one
// scan on an exact fit, else up to two scans plus one scan and one shift
// per split; a free that finds its block costs two scans plus one scan
// and one shift per merge. One request is in work at a time. After reset
// the block writes entry 0 (one free block of the top order) and then
// accepts requests. A result that the receiver has not taken sits in the
// output register; the next request is accepted meanwhile, and its own
// result waits until the register is free.
// ---------------------------------------------------------------------------
`include "buddy_block_allocator_macros.svh"

module buddy_block_allocator #(
	parameter int TABLE_SLOTS = bba_pkg::DEF_TABLE_SLOTS,
	parameter int TOP_ORDER   = bba_pkg::DEF_TOP_ORDER
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  logic [bba_pkg::SIZE_W-1:0] size_order,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      ok
);
	import bba_pkg::*;

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam int OW = order_width(TOP_ORDER);
	localparam int EW = OW + 1;

	localparam logic [4:0] S_INIT    = 5'd0;
	localparam logic [4:0] S_IDLE    = 5'd1;
	localparam logic [4:0] S_A1_REQ  = 5'd2;
	localparam logic [4:0] S_A1_CHK  = 5'd3;
	localparam logic [4:0] S_A2_STRT = 5'd4;
	localparam logic [4:0] S_A2_REQ  = 5'd5;
	localparam logic [4:0] S_A2_CHK  = 5'd6;
	localparam logic [4:0] S_SPL_REQ = 5'd7;
	localparam logic [4:0] S_SPL_WR  = 5'd8;
	localparam logic [4:0] S_SPL_LO  = 5'd9;
	localparam logic [4:0] S_SPL_HI  = 5'd10;
	localparam logic [4:0] S_F1_REQ  = 5'd11;
	localparam logic [4:0] S_F1_CHK  = 5'd12;
	localparam logic [4:0] S_F1_CLR  = 5'd13;
	localparam logic [4:0] S_M_REQ   = 5'd14;
	localparam logic [4:0] S_M_CHK   = 5'd15;
	localparam logic [4:0] S_M_UP    = 5'd16;
	localparam logic [4:0] S_RM_REQ  = 5'd17;
	localparam logic [4:0] S_RM_WR   = 5'd18;
	localparam logic [4:0] S_M_FIN   = 5'd19;
	localparam logic [4:0] S_DONE    = 5'd20;

	logic [4:0]    state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q, j_q, hit_q, first_q, last_q;
	logic [OW-1:0] want_q, tmp_q;
	logic          found_q, res_q, out_valid_q, ok_q;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, rd_data;

	logic          rd_used;
	logic [OW-1:0] rd_ord;
	logic          at_last, free_eq, m_found_n;
	logic [AW-1:0] m_first_n, m_last_n;

	bba_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	assign rd_used   = rd_data[OW];
	assign rd_ord    = rd_data[OW-1:0];
	assign at_last   = (CW'(idx_q) + CW'(1)) == count_q;
	assign free_eq   = !rd_used && (rd_ord == want_q);
	assign m_found_n = found_q | free_eq;
	assign m_first_n = (free_eq && !found_q) ? idx_q : first_q;
	assign m_last_n  = free_eq ? idx_q : last_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign ok        = ok_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = {1'b0, OW'(TOP_ORDER)};
			end
			S_A1_REQ, S_A2_REQ, S_F1_REQ, S_M_REQ: begin
				ram_re = 1'b1;
			end
			S_A1_CHK: begin
				ram_we    = free_eq;
				ram_wdata = {1'b1, rd_ord};
			end
			S_A2_CHK: begin
				ram_we    = free_eq;
				ram_wdata = {1'b1, rd_ord};
			end
			S_SPL_REQ: begin
				ram_re    = 1'b1;
				ram_raddr = j_q - AW'(1);
			end
			S_SPL_WR: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = rd_data;
			end
			S_SPL_LO: begin
				ram_we    = 1'b1;
				ram_waddr = hit_q;
				ram_wdata = {1'b0, tmp_q - OW'(1)};
			end
			S_SPL_HI: begin
				ram_we    = 1'b1;
				ram_waddr = hit_q + AW'(1);
				ram_wdata = {1'b0, tmp_q - OW'(1)};
			end
			S_F1_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = hit_q;
				ram_wdata = {1'b0, want_q};
			end
			S_M_UP: begin
				ram_we    = 1'b1;
				ram_waddr = first_q;
				ram_wdata = {1'b0, want_q + OW'(1)};
			end
			S_RM_REQ: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q + AW'(1);
			end
			S_RM_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = rd_data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			count_q     <= CW'(1);
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						want_q  <= OW'(size_order);
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= (cmd == CMD_FREE) ? S_F1_REQ : S_A1_REQ;
					end
				end
				S_A1_REQ: state_q <= S_A1_CHK;
				S_A1_CHK: begin
					if (free_eq) begin
						res_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (at_last) begin
						state_q <= S_A2_STRT;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_A1_REQ;
					end
				end
				S_A2_STRT: begin
					idx_q <= '0;
					if (count_q == CW'(TABLE_SLOTS)) begin
						res_q   <= 1'b0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_A2_REQ;
					end
				end
				S_A2_REQ: state_q <= S_A2_CHK;
				S_A2_CHK: begin
					if (!rd_used && rd_ord > want_q) begin
						hit_q   <= idx_q;
						tmp_q   <= rd_ord;
						j_q     <= AW'(count_q);
						state_q <= S_SPL_REQ;
					end else if (free_eq) begin
						res_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (at_last) begin
						res_q   <= 1'b0;
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_A2_REQ;
					end
				end
				S_SPL_REQ: state_q <= S_SPL_WR;
				S_SPL_WR: begin
					j_q     <= j_q - AW'(1);
					state_q <= ((j_q - AW'(1)) > hit_q) ? S_SPL_REQ : S_SPL_LO;
				end
				S_SPL_LO: state_q <= S_SPL_HI;
				S_SPL_HI: begin
					count_q <= count_q + CW'(1);
					state_q <= S_A2_STRT;
				end
				S_F1_REQ: state_q <= S_F1_CHK;
				S_F1_CHK: begin
					if (rd_used && rd_ord == want_q) begin
						hit_q   <= idx_q;
						found_q <= 1'b1;
					end
					if (at_last) begin
						if (found_q || (rd_used && rd_ord == want_q)) begin
							state_q <= S_F1_CLR;
						end else begin
							res_q   <= 1'b0;
							state_q <= S_DONE;
						end
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_F1_REQ;
					end
				end
				S_F1_CLR: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					state_q <= S_M_REQ;
				end
				S_M_REQ: state_q <= S_M_CHK;
				S_M_CHK: begin
					first_q <= m_first_n;
					last_q  <= m_last_n;
					found_q <= m_found_n;
					if (at_last) begin
						if (!m_found_n || m_first_n == m_last_n) begin
							res_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_M_UP;
						end
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_M_REQ;
					end
				end
				S_M_UP: begin
					idx_q   <= last_q;
					state_q <= ((CW + 1)'(last_q) + (CW + 1)'(2) <= (CW + 1)'(count_q))
						? S_RM_REQ : S_M_FIN;
				end
				S_RM_REQ: state_q <= S_RM_WR;
				S_RM_WR: begin
					idx_q   <= idx_q + AW'(1);
					state_q <= ((CW + 1)'(idx_q) + (CW + 1)'(3) <= (CW + 1)'(count_q))
						? S_RM_REQ : S_M_FIN;
				end
				S_M_FIN: begin
					// Removal done; retry the merge one order higher.
					count_q <= count_q - CW'(1);
					want_q  <= want_q + OW'(1);
					idx_q   <= '0;
					found_q <= 1'b0;
					state_q <= S_M_REQ;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						ok_q        <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BBA_ASSERT(a_count_range, clk, arst_n, (count_q >= CW'(1)) && (count_q <= CW'(TABLE_SLOTS)), "block count out of range")
	`BBA_ASSERT(a_no_rw_overlap, clk, arst_n, !(ram_we && ram_re), "table read and write in one cycle")
	`BBA_ASSERT(a_split_room, clk, arst_n, (state_q == S_SPL_HI) |-> (count_q < CW'(TABLE_SLOTS)), "split with a full table")
	`BBA_ASSERT(a_accept_busy, clk, arst_n, (in_valid && in_ready) |=> (state_q != S_IDLE), "request accepted but block stayed idle")
endmodule
